[design/sdr_pkg.sv]
// ----------------------------------------------------------------------------
// sdr_pkg
// Shared widths, codes and types for the sub-pixel disparity refine unit.
// ----------------------------------------------------------------------------
package sdr_pkg;

  localparam int DISP_W   = 9;
  localparam int COST_W   = 16;
  localparam int OUT_W    = 18;
  localparam int METHOD_W = 2;
  localparam int DIFF_W   = 20;   // signed numerator / divisor
  localparam int DEN_W    = 19;   // divisor magnitude
  localparam int REM_W    = 20;   // partial remainder, below twice the divisor when ovf is clear

  localparam int DEF_MAX_DISPARITY = 255;
  localparam int DEF_FRACTION_BITS = 8;
  localparam int INVALID_DISPARITY = -10;

  localparam logic [METHOD_W-1:0] FIT_EQUIANGULAR = 2'd0;
  localparam logic [METHOD_W-1:0] FIT_PARABOLIC   = 2'd1;
  localparam logic [METHOD_W-1:0] FIT_PASS        = 2'd2;

  typedef struct packed {
    logic bypass;  // no offset: edge, pass mode, invalid or zero divisor
    logic neg;     // offset is negative
    logic ovf;     // quotient certainly beyond one pixel
  } sdr_ctrl_t;

endpackage

[design/sdr_if.sv]
// ----------------------------------------------------------------------------
// sdr_in_if / sdr_out_if
// Valid/ready channels carrying pixel items into and refined items out of
// the refine unit.
// ----------------------------------------------------------------------------
interface sdr_in_if import sdr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DISP_W-1:0] disparity_in;
  logic [COST_W-1:0]        cost_below;
  logic [COST_W-1:0]        cost_center;
  logic [COST_W-1:0]        cost_above;
  logic                     at_row_edge;

  modport source (output valid, disparity_in, cost_below, cost_center, cost_above,
                  at_row_edge, input ready);
  modport sink   (input valid, disparity_in, cost_below, cost_center, cost_above,
                  at_row_edge, output ready);
endinterface

interface sdr_out_if import sdr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] refined_disparity;

  modport source (output valid, refined_disparity, input ready);
  modport sink   (input valid, refined_disparity, output ready);
endinterface

[design/subpixel_disparity_refine_unit.sv]
// ----------------------------------------------------------------------------
// subpixel_disparity_refine_unit
// Refines integer winner disparities to signed fixed point by an equiangular
// or parabolic fit over the three neighbouring matching costs.
// ----------------------------------------------------------------------------
// Takes one item per clock and returns one item per clock while the sink is
// ready. Each item passes through one front stage, a row of FRACTION_BITS + 1
// restoring-division cells that each settle one quotient bit, and a registered
// output stage. Every stage holds its item only while the one after it is full
// and stalled, so gaps close up under back-pressure.
// fit_method: 0 equiangular, 1 parabolic, 2 or 3 pass through; write it only
// while the unit is empty.
// ----------------------------------------------------------------------------
module subpixel_disparity_refine_unit import sdr_pkg::*; #(
  parameter int MAX_DISPARITY = DEF_MAX_DISPARITY,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [METHOD_W-1:0] cfg_wr_data,
  sdr_in_if.sink              in_item,
  sdr_out_if.source           out_item
);

  localparam int QUO_W   = FRACTION_BITS + 1;
  localparam int N_CELLS = FRACTION_BITS + 1;

  logic [METHOD_W-1:0] fit_method_r;

  logic                    valid_s [N_CELLS+1];
  logic                    ready_s [N_CELLS+1];
  logic [REM_W-1:0]        rem_s   [N_CELLS+1];
  logic [DEN_W-1:0]        den_s   [N_CELLS+1];
  logic [QUO_W-1:0]        quo_s   [N_CELLS+1];
  sdr_ctrl_t               ctrl_s  [N_CELLS+1];
  logic signed [OUT_W-1:0] base_s  [N_CELLS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_method_r <= FIT_EQUIANGULAR;
    end else if (cfg_wr_en) begin
      fit_method_r <= cfg_wr_data;
    end
  end

  sdr_prep #(
    .MAX_DISPARITY (MAX_DISPARITY),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .fit_method (fit_method_r),
    .in_ch      (in_item),
    .valid_o    (valid_s[0]),
    .ready_i    (ready_s[0]),
    .rem_o      (rem_s[0]),
    .den_o      (den_s[0]),
    .ctrl_o     (ctrl_s[0]),
    .base_o     (base_s[0])
  );

  assign quo_s[0] = '0;

  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    sdr_div_cell #(
      .QUO_W (QUO_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (valid_s[g]),
      .ready_o (ready_s[g]),
      .rem_i   (rem_s[g]),
      .den_i   (den_s[g]),
      .quo_i   (quo_s[g]),
      .ctrl_i  (ctrl_s[g]),
      .base_i  (base_s[g]),
      .valid_o (valid_s[g+1]),
      .ready_i (ready_s[g+1]),
      .rem_o   (rem_s[g+1]),
      .den_o   (den_s[g+1]),
      .quo_o   (quo_s[g+1]),
      .ctrl_o  (ctrl_s[g+1]),
      .base_o  (base_s[g+1])
    );
  end

  sdr_finish #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_finish (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (valid_s[N_CELLS]),
    .ready_o (ready_s[N_CELLS]),
    .quo_i   (quo_s[N_CELLS]),
    .ctrl_i  (ctrl_s[N_CELLS]),
    .base_i  (base_s[N_CELLS]),
    .out_ch  (out_item)
  );

endmodule

[design/sdr_prep.sv]
// ----------------------------------------------------------------------------
// sdr_prep
// Front stage: forms numerator and divisor of the fit, their magnitudes and
// signs, the integer base value and the bypass cases.
// ----------------------------------------------------------------------------
module sdr_prep import sdr_pkg::*; #(
  parameter int MAX_DISPARITY = DEF_MAX_DISPARITY,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [METHOD_W-1:0]     fit_method,
  sdr_in_if.sink                  in_ch,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [REM_W-1:0]        rem_o,
  output logic [DEN_W-1:0]        den_o,
  output sdr_ctrl_t               ctrl_o,
  output logic signed [OUT_W-1:0] base_o
);

  localparam int MAX_BITS = $clog2(MAX_DISPARITY + 1);
  localparam int CMP_W    = (MAX_BITS > DISP_W - 1 ? MAX_BITS : DISP_W - 1) + 1;
  localparam logic signed [CMP_W-1:0] MAX_C = CMP_W'(MAX_DISPARITY);
  localparam logic signed [OUT_W-1:0] INVALID_C =
    OUT_W'(INVALID_DISPARITY) <<< FRACTION_BITS;

  logic                     valid_r;
  logic [REM_W-1:0]         rem_r,  rem_nxt;
  logic [DEN_W-1:0]         den_r,  den_nxt;
  sdr_ctrl_t                ctrl_r, ctrl_nxt;
  logic signed [OUT_W-1:0]  base_r, base_nxt;

  logic signed [CMP_W-1:0]  d_ext, d_sat;
  logic signed [DIFF_W-1:0] c0, c1, c2, left, right, num, den, num_abs, den_abs;
  logic                     load;

  assign in_ch.ready = !valid_r || ready_i;
  assign load        = in_ch.ready && in_ch.valid;

  always_comb begin
    d_ext = CMP_W'(in_ch.disparity_in);
    d_sat = (d_ext > MAX_C) ? MAX_C : d_ext;
    c0    = DIFF_W'(in_ch.cost_below);
    c1    = DIFF_W'(in_ch.cost_center);
    c2    = DIFF_W'(in_ch.cost_above);
    left  = c1 - c0;
    right = c1 - c2;
    if (fit_method == FIT_EQUIANGULAR) begin
      num = c2 - c0;
      den = ((left < right) ? left : right) <<< 1;
    end else begin
      num = c0 - c2;
      den = (c0 <<< 1) - (c1 <<< 2) + (c2 <<< 1);
    end
    num_abs = num[DIFF_W-1] ? -num : num;
    den_abs = den[DIFF_W-1] ? -den : den;

    rem_nxt         = REM_W'(num_abs);
    den_nxt         = DEN_W'(den_abs);
    ctrl_nxt.neg    = num[DIFF_W-1] ^ den[DIFF_W-1];
    ctrl_nxt.ovf    = REM_W'(num_abs) >= (REM_W'(den_abs) << 1);
    ctrl_nxt.bypass = (den == '0);
    base_nxt        = OUT_W'(d_sat) <<< FRACTION_BITS;

    if (in_ch.at_row_edge || fit_method == FIT_PASS || fit_method[1]) begin
      ctrl_nxt.bypass = 1'b1;
      base_nxt        = OUT_W'(in_ch.disparity_in) <<< FRACTION_BITS;
    end else if (in_ch.disparity_in <= 0) begin
      ctrl_nxt.bypass = 1'b1;
      base_nxt        = INVALID_C;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r  <= rem_nxt;
      den_r  <= den_nxt;
      ctrl_r <= ctrl_nxt;
      base_r <= base_nxt;
    end
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign den_o   = den_r;
  assign ctrl_o  = ctrl_r;
  assign base_o  = base_r;

endmodule

[design/sdr_div_cell.sv]
// ----------------------------------------------------------------------------
// sdr_div_cell
// One restoring-division cell: settles one quotient bit and hands the
// shifted remainder on to the next cell.
// ----------------------------------------------------------------------------
module sdr_div_cell import sdr_pkg::*; #(
  parameter int QUO_W = DEF_FRACTION_BITS + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [REM_W-1:0]        rem_i,
  input  logic [DEN_W-1:0]        den_i,
  input  logic [QUO_W-1:0]        quo_i,
  input  sdr_ctrl_t               ctrl_i,
  input  logic signed [OUT_W-1:0] base_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [REM_W-1:0]        rem_o,
  output logic [DEN_W-1:0]        den_o,
  output logic [QUO_W-1:0]        quo_o,
  output sdr_ctrl_t               ctrl_o,
  output logic signed [OUT_W-1:0] base_o
);

  logic                    valid_r;
  logic [REM_W-1:0]        rem_r, rem_nxt;
  logic [DEN_W-1:0]        den_r;
  logic [QUO_W-1:0]        quo_r, quo_nxt;
  sdr_ctrl_t               ctrl_r;
  logic signed [OUT_W-1:0] base_r;
  logic [REM_W-1:0]        diff;
  logic                    bit_q;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    diff    = rem_i - REM_W'(den_i);
    bit_q   = rem_i >= REM_W'(den_i);
    rem_nxt = (bit_q ? diff : rem_i) << 1;
    quo_nxt = {quo_i[QUO_W-2:0], bit_q};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      rem_r  <= rem_nxt;
      den_r  <= den_i;
      quo_r  <= quo_nxt;
      ctrl_r <= ctrl_i;
      base_r <= base_i;
    end
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign den_o   = den_r;
  assign quo_o   = quo_r;
  assign ctrl_o  = ctrl_r;
  assign base_o  = base_r;

endmodule

[design/sdr_finish.sv]
// ----------------------------------------------------------------------------
// sdr_finish
// Output stage: clamps the quotient to one pixel, applies its sign, adds it
// to the base value and holds the result item for the sink.
// ----------------------------------------------------------------------------
module sdr_finish import sdr_pkg::*; #(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [FRACTION_BITS:0]    quo_i,
  input  sdr_ctrl_t                 ctrl_i,
  input  logic signed [OUT_W-1:0]   base_i,
  sdr_out_if.source                 out_ch
);

  localparam logic signed [OUT_W-1:0] ONE_C = OUT_W'(1) <<< FRACTION_BITS;

  logic                    valid_r;
  logic signed [OUT_W-1:0] disp_r, disp_nxt;
  logic signed [OUT_W-1:0] mag, offset;

  assign ready_o = !valid_r || out_ch.ready;

  always_comb begin
    mag = OUT_W'(quo_i);
    if (ctrl_i.ovf || mag > ONE_C) begin
      mag = ONE_C;
    end
    offset = ctrl_i.neg ? -mag : mag;
    if (ctrl_i.bypass) begin
      offset = '0;
    end
    disp_nxt = base_i + offset;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      disp_r <= disp_nxt;
    end
  end

  assign out_ch.valid             = valid_r;
  assign out_ch.refined_disparity = disp_r;

endmodule

[tb/subpixel_disparity_refine_unit_tb.sv]
// ----------------------------------------------------------------------------
// subpixel_disparity_refine_unit_tb
// Self-checking bench for the sub-pixel disparity refine unit. A queue-fed
// driver streams pixel items, a clocked monitor predicts each refined
// disparity at acceptance and checks results in order. It runs a directed
// set, then random phases over every fit method with varied back-pressure.
// ----------------------------------------------------------------------------
module subpixel_disparity_refine_unit_tb;
  import sdr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [METHOD_W-1:0] FIT_PASS_ALT = 2'd3;
  localparam int N_PHASES     = 12;
  localparam int PHASE_ITEMS  = 163;
  localparam int DRAIN_CYCLES = 2 * (DEF_FRACTION_BITS + 3) + 4;

  typedef struct packed {
    logic signed [DISP_W-1:0] disp;
    logic [COST_W-1:0]        c0;
    logic [COST_W-1:0]        c1;
    logic [COST_W-1:0]        c2;
    logic                     row_edge;
  } pixel_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [METHOD_W-1:0] cfg_wr_data;

  sdr_in_if  in_if ();
  sdr_out_if out_if ();

  subpixel_disparity_refine_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_item    (in_if),
    .out_item   (out_if)
  );

  pixel_t                  pending_pixels[$];
  logic signed [OUT_W-1:0] expected_refined[$];
  logic [METHOD_W-1:0]     fit_mode_q;
  int                      send_idle_pct;
  int                      recv_idle_pct;
  int                      err_cnt;
  int                      n_sent;
  int                      n_checked;
  int                      n_cfg_writes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic signed [OUT_W-1:0] refine_disparity(
    logic [METHOD_W-1:0] method, pixel_t px);
    longint one, d, c0, c1, c2, num, den, offs, lft, rgt;
    one = longint'(1) << DEF_FRACTION_BITS;
    d   = longint'(px.disp);
    c0  = longint'(px.c0);
    c1  = longint'(px.c1);
    c2  = longint'(px.c2);
    if (px.row_edge || method >= FIT_PASS) return OUT_W'(d * one);
    if (d <= 0) return OUT_W'(INVALID_DISPARITY * one);
    if (d > DEF_MAX_DISPARITY) d = DEF_MAX_DISPARITY;
    if (method == FIT_EQUIANGULAR) begin
      lft = c1 - c0;
      rgt = c1 - c2;
      num = c2 - c0;
      den = 2 * ((lft < rgt) ? lft : rgt);
    end else begin
      num = c0 - c2;
      den = 2 * c0 - 4 * c1 + 2 * c2;
    end
    offs = 0;
    if (den != 0) begin
      offs = (num * one) / den;
      if (offs > one) offs = one;
      if (offs < -one) offs = -one;
    end
    return OUT_W'(d * one + offs);
  endfunction

  function automatic pixel_t mk_pixel(int d, int c0, int c1, int c2, bit e);
    pixel_t px;
    px.disp     = DISP_W'(d);
    px.c0       = COST_W'(c0);
    px.c1       = COST_W'(c1);
    px.c2       = COST_W'(c2);
    px.row_edge = e;
    return px;
  endfunction

  function automatic pixel_t rand_pixel();
    int r, sel, d, c0, c1, c2;
    r = $urandom_range(99);
    if (r < 80) d = $urandom_range(255, 1);
    else if (r < 95) d = -$urandom_range(16, 0);
    else d = ($urandom_range(1) != 0) ? 255 : 1;
    sel = $urandom_range(99);
    if (sel < 50) begin
      // typical winner: centre cost at or near the minimum
      c1 = $urandom_range(4000);
      c0 = c1 + $urandom_range(2000);
      c2 = c1 + $urandom_range(2000);
    end else if (sel < 60) begin
      c1 = $urandom_range(1000);
      c0 = c1 + $urandom_range(64000);
      c2 = c1 + $urandom_range(64000);
    end else if (sel < 75) begin
      c0 = $urandom_range(15);
      c1 = $urandom_range(15);
      c2 = $urandom_range(15);
    end else if (sel < 90) begin
      c0 = $urandom_range(65535);
      c1 = $urandom_range(65535);
      c2 = $urandom_range(65535);
    end else if (sel < 95) begin
      c0 = $urandom_range(65535);
      c1 = c0;
      c2 = c0;
    end else begin
      c0 = ($urandom_range(1) != 0) ? 65535 : 0;
      c1 = ($urandom_range(1) != 0) ? 65535 : 0;
      c2 = ($urandom_range(1) != 0) ? 65535 : 0;
    end
    return mk_pixel(d, c0, c1, c2, $urandom_range(9) == 0);
  endfunction

  // driver
  always @(posedge clk) begin : drive_proc
    pixel_t px;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        px = pending_pixels.pop_front();
        in_if.valid        <= 1'b1;
        in_if.disparity_in <= px.disp;
        in_if.cost_below   <= px.c0;
        in_if.cost_center  <= px.c1;
        in_if.cost_above   <= px.c2;
        in_if.at_row_edge  <= px.row_edge;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_if.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor and checker
  always @(posedge clk) begin : check_proc
    logic signed [OUT_W-1:0] want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_refined.size() == 0) begin
          $error("refined_disparity: unexpected item, actual %0d",
                 out_if.refined_disparity);
          err_cnt++;
        end else begin
          want = expected_refined.pop_front();
          n_checked++;
          if (out_if.refined_disparity !== want) begin
            $error("refined_disparity: expected %0d, actual %0d",
                   want, out_if.refined_disparity);
            err_cnt++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        n_sent++;
        expected_refined.push_back(refine_disparity(fit_mode_q,
          mk_pixel(int'(in_if.disparity_in), int'(in_if.cost_below),
                   int'(in_if.cost_center), int'(in_if.cost_above),
                   in_if.at_row_edge)));
      end
    end
  end

  task automatic drain_pipe();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || in_if.valid || expected_refined.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_fit_method(logic [METHOD_W-1:0] m);
    drain_pipe();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    fit_mode_q  <= m;
    n_cfg_writes++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_directed(int n);
    pixel_t set[12];
    set[0]  = mk_pixel(1, 100, 50, 120, 1'b0);
    set[1]  = mk_pixel(-16, 10, 5, 20, 1'b0);
    set[2]  = mk_pixel(255, 0, 0, 65535, 1'b0);
    set[3]  = mk_pixel(255, 65535, 0, 0, 1'b0);
    set[4]  = mk_pixel(128, 10, 10, 10, 1'b0);
    set[5]  = mk_pixel(0, 10, 5, 20, 1'b0);
    set[6]  = mk_pixel(-16, 65535, 65535, 65535, 1'b1);
    set[7]  = mk_pixel(255, 1, 0, 65535, 1'b1);
    set[8]  = mk_pixel(37, 65535, 1, 65534, 1'b0);
    set[9]  = mk_pixel(200, 300, 1000, 200, 1'b0);
    set[10] = mk_pixel(-1, 0, 65535, 0, 1'b0);
    set[11] = mk_pixel(100, 5, 3, 4, 1'b0);
    for (int i = 0; i < n; i++) pending_pixels.push_back(set[i]);
  endtask

  initial begin
    logic [METHOD_W-1:0] phase_mode[N_PHASES];
    phase_mode = '{FIT_EQUIANGULAR, FIT_PARABOLIC, FIT_EQUIANGULAR, FIT_PARABOLIC,
                   FIT_PASS, FIT_EQUIANGULAR, FIT_PARABOLIC, FIT_PASS_ALT,
                   FIT_EQUIANGULAR, FIT_PARABOLIC, FIT_EQUIANGULAR, FIT_PARABOLIC};
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = FIT_EQUIANGULAR;
    fit_mode_q         = FIT_EQUIANGULAR;
    send_idle_pct      = 34;
    recv_idle_pct      = 70;
    err_cnt            = 0;
    n_sent             = 0;
    n_checked          = 0;
    n_cfg_writes       = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    write_fit_method(FIT_EQUIANGULAR);
    push_directed(12);
    write_fit_method(FIT_PARABOLIC);
    push_directed(12);
    write_fit_method(FIT_PASS);
    push_directed(2);
    write_fit_method(FIT_PASS_ALT);
    push_directed(2);

    for (int p = 0; p < N_PHASES; p++) begin
      write_fit_method(phase_mode[p]);
      send_idle_pct = (p < 4) ? 34 : (p < 8) ? 70 : 0;
      recv_idle_pct = (p < 4) ? 70 : (p < 8) ? 34 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pending_pixels.push_back(rand_pixel());
        // sender holds off mid-phase until the unit is empty
        if (p == 2 && i == PHASE_ITEMS / 2) drain_pipe();
      end
    end

    drain_pipe();
    $display("Covered %0d pixel items and %0d checked results over %0d fit-method writes,",
             n_sent, n_checked, n_cfg_writes);
    $display("modes 0 to 3 with edge, invalid, zero-divisor and clamp cases.");
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
